// File: hdl/abl_pkg.sv
// Shared types and constants for the straight-alpha over compositor.
package abl_pkg;

  localparam int NUM_CH = 3;   // colour channels: 0 red, 1 green, 2 blue
  localparam int QUO_W  = 8;   // quotient bits, one divider stage each
  localparam int NUM_W  = 17;  // channel numerator width

  localparam logic [7:0]  ALPHA_MAX = 8'd255;
  localparam logic [7:0]  RND_255   = 8'd127;
  localparam logic [24:0] RECIP_255 = 25'h1010101;  // floor(2^32 / 255)

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  // Output of the product and divide-by-255 front end.
  typedef struct packed {
    logic                     valid;
    logic                     bypass;
    pix_t                     pass;
    logic [7:0]               ra;
    logic [NUM_CH-1:0][15:0]  p;
    logic [NUM_CH-1:0][15:0]  q;
  } prep_t;

  // One transaction inside the channel divider.
  typedef struct packed {
    logic                          valid;
    logic                          bypass;
    pix_t                          pass;
    logic [7:0]                    ra;
    logic [NUM_CH-1:0]             sat;
    logic [NUM_CH-1:0][NUM_W-1:0]  rem;
    logic [NUM_CH-1:0][QUO_W-1:0]  quo;
  } div_t;

endpackage

// File: hdl/abl_prep.sv
// Front end: premultiplied terms, output alpha and rounded divide by 255.
module abl_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  abl_pkg::pix_t over_pix,
  input  abl_pkg::pix_t base_pix,
  output abl_pkg::prep_t prep_o
);

  typedef struct packed {
    logic                            valid;
    logic                            bypass;
    abl_pkg::pix_t                   pass;
    logic [7:0]                      oa;
    logic [15:0]                     w;
    logic [abl_pkg::NUM_CH-1:0][15:0] p;
    logic [abl_pkg::NUM_CH-1:0][7:0]  bc;
  } s1_t;

  typedef struct packed {
    logic                            valid;
    logic                            bypass;
    abl_pkg::pix_t                   pass;
    logic [7:0]                      oa;
    logic [15:0]                     ya;
    logic [abl_pkg::NUM_CH-1:0][15:0] p;
    logic [abl_pkg::NUM_CH-1:0][23:0] yc;
  } s2_t;

  typedef struct packed {
    logic                            valid;
    logic                            bypass;
    abl_pkg::pix_t                   pass;
    logic [7:0]                      oa;
    logic [15:0]                     ya;
    logic [15:0]                     qa0;
    logic [abl_pkg::NUM_CH-1:0][15:0] p;
    logic [abl_pkg::NUM_CH-1:0][23:0] yc;
    logic [abl_pkg::NUM_CH-1:0][15:0] qc0;
  } s3_t;

  // Reciprocal estimate of y / 255: exact or one low.
  function automatic logic [15:0] div255_est(input logic [23:0] y);
    logic [48:0] prod;
    prod = {25'b0, y} * {24'b0, abl_pkg::RECIP_255};
    return prod[47:32];
  endfunction

  function automatic logic [15:0] div255_fix(input logic [23:0] y, input logic [15:0] q0);
    logic [23:0] back;
    logic [23:0] r;
    back = {q0, 8'b0} - {8'b0, q0};
    r    = y - back;
    return (r >= 24'd255) ? q0 + 16'd1 : q0;
  endfunction

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  abl_pkg::prep_t s4_r, s4_nxt;

  logic [abl_pkg::NUM_CH-1:0][7:0] oc;
  logic [7:0] ia;

  assign oc[0] = over_pix.red;
  assign oc[1] = over_pix.green;
  assign oc[2] = over_pix.blue;

  // Stage 1: inverse alpha, base weight, overlay premultiply, pass-through pick.
  always_comb begin
    ia            = abl_pkg::ALPHA_MAX - over_pix.alpha;
    s1_nxt.valid  = in_valid;
    s1_nxt.bypass = (over_pix.alpha == 8'd0) || (over_pix.alpha == abl_pkg::ALPHA_MAX);
    s1_nxt.pass   = (over_pix.alpha == 8'd0) ? base_pix : over_pix;
    s1_nxt.oa     = over_pix.alpha;
    s1_nxt.w      = {8'b0, base_pix.alpha} * {8'b0, ia};
    s1_nxt.bc[0]  = base_pix.red;
    s1_nxt.bc[1]  = base_pix.green;
    s1_nxt.bc[2]  = base_pix.blue;
    for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
      s1_nxt.p[c] = {8'b0, oc[c]} * {8'b0, over_pix.alpha};
    end
  end

  // Stage 2: base colour times weight, rounding offsets.
  always_comb begin
    s2_nxt.valid  = s1_r.valid;
    s2_nxt.bypass = s1_r.bypass;
    s2_nxt.pass   = s1_r.pass;
    s2_nxt.oa     = s1_r.oa;
    s2_nxt.p      = s1_r.p;
    s2_nxt.ya     = s1_r.w + {8'b0, abl_pkg::RND_255};
    for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
      s2_nxt.yc[c] = ({16'b0, s1_r.bc[c]} * {8'b0, s1_r.w}) + {16'b0, abl_pkg::RND_255};
    end
  end

  // Stage 3: reciprocal estimates.
  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.bypass = s2_r.bypass;
    s3_nxt.pass   = s2_r.pass;
    s3_nxt.oa     = s2_r.oa;
    s3_nxt.p      = s2_r.p;
    s3_nxt.ya     = s2_r.ya;
    s3_nxt.yc     = s2_r.yc;
    s3_nxt.qa0    = div255_est({8'b0, s2_r.ya});
    for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
      s3_nxt.qc0[c] = div255_est(s2_r.yc[c]);
    end
  end

  // Stage 4: one-step correction, output alpha (never above 255).
  always_comb begin
    logic [15:0] qa;
    qa            = div255_fix({8'b0, s3_r.ya}, s3_r.qa0);
    s4_nxt.valid  = s3_r.valid;
    s4_nxt.bypass = s3_r.bypass;
    s4_nxt.pass   = s3_r.pass;
    s4_nxt.p      = s3_r.p;
    s4_nxt.ra     = s3_r.oa + qa[7:0];
    for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
      s4_nxt.q[c] = div255_fix(s3_r.yc[c], s3_r.qc0[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign prep_o = s4_r;

endmodule

// File: hdl/abl_divider.sv
// Pipelined restoring divider: one quotient bit per stage for all channels.
module abl_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  abl_pkg::div_t div_i,
  output abl_pkg::div_t div_o
);

  abl_pkg::div_t st_r [abl_pkg::QUO_W];

  for (genvar s = 0; s < abl_pkg::QUO_W; s++) begin : g_stage
    localparam int BIT = abl_pkg::QUO_W - 1 - s;

    abl_pkg::div_t st_in;
    abl_pkg::div_t stg_nxt;
    logic [abl_pkg::NUM_W-1:0] dsr;

    if (s == 0) begin : g_first
      assign st_in = div_i;
    end else begin : g_rest
      assign st_in = st_r[s-1];
    end

    always_comb begin
      dsr     = {{(abl_pkg::NUM_W-8){1'b0}}, st_in.ra} << BIT;
      stg_nxt = st_in;
      for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
        if (st_in.rem[c] >= dsr) begin
          stg_nxt.rem[c]      = st_in.rem[c] - dsr;
          stg_nxt.quo[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].valid <= 1'b0;
      end else begin
        st_r[s] <= stg_nxt;
      end
    end
  end

  assign div_o = st_r[abl_pkg::QUO_W-1];

endmodule

// File: hdl/argb_over_blend.sv
// 14 register stages lie between the accepting edge and the out_ ports.
// Throughput: one pixel pair per clock; busy is held low, so start may be high every cycle.
// Cost is set by the 8-stage channel divider (one quotient bit per stage) plus 6 other stages.
// The receiver cannot stall: out_valid strobes for exactly one cycle per result.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
module argb_over_blend (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_over_red,
  input  logic [7:0] in_over_green,
  input  logic [7:0] in_over_blue,
  input  logic [7:0] in_over_alpha,
  input  logic [7:0] in_base_red,
  input  logic [7:0] in_base_green,
  input  logic [7:0] in_base_blue,
  input  logic [7:0] in_base_alpha,
  output logic       out_valid,
  output logic [7:0] out_mix_red,
  output logic [7:0] out_mix_green,
  output logic [7:0] out_mix_blue,
  output logic [7:0] out_mix_alpha
);

  abl_pkg::pix_t  over_pix;
  abl_pkg::pix_t  base_pix;
  abl_pkg::prep_t prep;
  abl_pkg::div_t  d0_r, d0_nxt;
  abl_pkg::div_t  dq;
  abl_pkg::pix_t  out_pix_r, out_pix_nxt;
  logic           out_valid_r;

  // Fully pipelined: nothing ever holds a transaction back.
  assign busy = 1'b0;

  assign over_pix = '{red: in_over_red, green: in_over_green, blue: in_over_blue,
                      alpha: in_over_alpha};
  assign base_pix = '{red: in_base_red, green: in_base_green, blue: in_base_blue,
                      alpha: in_base_alpha};

  // Stages 1-4: products, output alpha, base term rounded by 255.
  abl_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .over_pix (over_pix),
    .base_pix (base_pix),
    .prep_o   (prep)
  );

  // Stage 5: numerator with half-divisor rounding, and overflow check.
  // A quotient of 256 or more means numerator >= ra * 256; such channels clamp to 255,
  // which also leaves the divider needing only eight quotient bits.
  // On the blend path ra >= over alpha >= 1, so the zero-alpha case never reaches here.
  always_comb begin
    logic [abl_pkg::NUM_W-1:0] num;
    d0_nxt        = '0;
    d0_nxt.valid  = prep.valid;
    d0_nxt.bypass = prep.bypass;
    d0_nxt.pass   = prep.pass;
    d0_nxt.ra     = prep.ra;
    for (int c = 0; c < abl_pkg::NUM_CH; c++) begin
      num = {1'b0, prep.p[c]} + {1'b0, prep.q[c]}
          + {{(abl_pkg::NUM_W-7){1'b0}}, prep.ra[7:1]};
      d0_nxt.rem[c] = num;
      d0_nxt.sat[c] = (num >= {1'b0, prep.ra, 8'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r.valid <= 1'b0;
    end else begin
      d0_r <= d0_nxt;
    end
  end

  // Stages 6-13: colour channel divide by output alpha.
  abl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .div_i (d0_r),
    .div_o (dq)
  );

  // Stage 14: transparent overlay passes the base, opaque overlay passes itself,
  // otherwise the (saturated) quotients with the blended alpha.
  always_comb begin
    if (dq.bypass) begin
      out_pix_nxt = dq.pass;
    end else begin
      out_pix_nxt.red   = dq.sat[0] ? abl_pkg::ALPHA_MAX : dq.quo[0];
      out_pix_nxt.green = dq.sat[1] ? abl_pkg::ALPHA_MAX : dq.quo[1];
      out_pix_nxt.blue  = dq.sat[2] ? abl_pkg::ALPHA_MAX : dq.quo[2];
      out_pix_nxt.alpha = dq.ra;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dq.valid;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mix_red   = out_pix_r.red;
  assign out_mix_green = out_pix_r.green;
  assign out_mix_blue  = out_pix_r.blue;
  assign out_mix_alpha = out_pix_r.alpha;

endmodule
